// File: src/boundary_tag_first_fit_allocator_defines.svh
// assertion macros for the boundary tag allocator
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_DEFINES_SVH

// same-cycle implication on clock, disabled in reset
`define BTA_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("allocator check failed");

// next-cycle implication on clock, disabled in reset
`define BTA_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("allocator check failed");

`endif

// File: src/bta_pkg.sv
package bta_pkg;

   localparam int HEAP_BYTES  = 4096;
   localparam int LEAD_BYTES  = 16;
   localparam int HDR_BYTES   = 16;
   localparam int SPLIT_BYTES = 24;
   localparam int WORDS       = HEAP_BYTES / 8;
   localparam int IDX_W       = $clog2(WORDS);
   localparam int OFF_W       = $clog2(HEAP_BYTES) + 1;
   localparam int TAG_W       = OFF_W;
   localparam int FLD_W       = 12;
   localparam int QUEUE_DEPTH = 4;
   localparam int QI_W        = $clog2(QUEUE_DEPTH);
   localparam int QN_W        = $clog2(QUEUE_DEPTH + 1);

   typedef logic [OFF_W-1:0] off_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [TAG_W-1:0] tag_type;
   typedef logic [QI_W-1:0]  qidx_type;
   typedef logic [QN_W-1:0]  qcnt_type;

   localparam off_type HDR      = off_type'(HDR_BYTES);
   localparam off_type SPLIT    = off_type'(SPLIT_BYTES);
   localparam off_type LEAD_OFF = off_type'(LEAD_BYTES);
   localparam off_type TAG_STEP = off_type'(8);
   localparam tag_type INIT_TAG = tag_type'(HEAP_BYTES - LEAD_BYTES - HDR_BYTES);

   typedef enum logic [1:0] {
      REQ_ALLOC  = 2'd0,
      REQ_FREE   = 2'd1,
      REQ_RESIZE = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_FIND_RD,
      ST_FIND_CK,
      ST_RZ_RD,
      ST_RZ_CK,
      ST_AL_RD,
      ST_AL_CK,
      ST_FR_RD,
      ST_FR_PV,
      ST_FR_CK,
      ST_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
      tag_type data;
   } tag_wr_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
   } tag_rd_type;

   function automatic idx_type word_of(input off_type o);
      return o[IDX_W+2:3];
   endfunction

   function automatic off_type size_of(input tag_type t);
      return {t[TAG_W-1:3], 3'b000};
   endfunction

   function automatic tag_type mk_tag(input off_type s, input logic al);
      return {s[OFF_W-1:1], al};
   endfunction

endpackage

// File: src/boundary_tag_first_fit_allocator.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_type, req_size, req_addr
// rsp       out        rsp_valid/rsp_stall  rsp_ok, rsp_result_addr, rsp_move_needed,
//                                           rsp_move_from, rsp_move_bytes
// one item at a time; the tag memory's single read port sets the pace
// list walks read and check one tag per block visited; tag writes drain one at a time from a queue
// free and resize walk to the block first; free then reads the neighbour tags, resize reads the next header
// after reset the init state writes the initial heap header while req_stall is high
// a result waiting under rsp_stall holds the next result in the done state
`include "boundary_tag_first_fit_allocator_defines.svh"

module boundary_tag_first_fit_allocator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic [bta_pkg::FLD_W-1:0] req_size,
   input  logic [bta_pkg::FLD_W-1:0] req_addr,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_ok,
   output logic [bta_pkg::FLD_W-1:0] rsp_result_addr,
   output logic                      rsp_move_needed,
   output logic [bta_pkg::FLD_W-1:0] rsp_move_from,
   output logic [bta_pkg::FLD_W-1:0] rsp_move_bytes
);
   import bta_pkg::*;

   state_type    state_ff, state_in, after_ff, after_in;
   req_code_type type_ff, type_in;
   off_type      a_ff, a_in, hdr_ff, hdr_in, p_ff, p_in, cs_ff, cs_in, last_ff, last_in;
   tag_type      pv_ff, pv_in;
   logic [FLD_W-1:0] addr_ff, addr_in;
   logic         move_ff, move_in;
   logic         res_ok_ff, res_ok_in, res_mv_ff, res_mv_in;
   logic [FLD_W-1:0] res_addr_ff, res_addr_in;

   idx_type      q_addr_ff [QUEUE_DEPTH];
   tag_type      q_data_ff [QUEUE_DEPTH];
   idx_type      pl_addr [QUEUE_DEPTH];
   tag_type      pl_data [QUEUE_DEPTH];
   logic         load_q;
   qcnt_type     q_n_ff, q_n_in;
   qidx_type     wr_idx_ff, wr_idx_in;

   logic         rsp_valid_ff, rsp_valid_in, rsp_load;
   logic         rsp_ok_ff, rsp_mv_ff;
   logic [FLD_W-1:0] rsp_addr_ff, rsp_from_ff, rsp_bytes_ff;

   tag_wr_type   wr;
   tag_rd_type   rd;
   tag_type      rd_data;

   bta_tag_ram u_tags (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         after_ff     <= ST_DONE;
         last_ff      <= LEAD_OFF;
         wr_idx_ff    <= '0;
         q_n_ff       <= '0;
         move_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         last_ff      <= last_in;
         wr_idx_ff    <= wr_idx_in;
         q_n_ff       <= q_n_in;
         move_ff      <= move_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      a_ff        <= a_in;
      hdr_ff      <= hdr_in;
      p_ff        <= p_in;
      cs_ff       <= cs_in;
      pv_ff       <= pv_in;
      addr_ff     <= addr_in;
      res_ok_ff   <= res_ok_in;
      res_mv_ff   <= res_mv_in;
      res_addr_ff <= res_addr_in;
      if (load_q) begin
         q_addr_ff <= pl_addr;
         q_data_ff <= pl_data;
      end
      if (rsp_load) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_addr_ff  <= res_addr_ff;
         rsp_mv_ff    <= res_mv_ff;
         rsp_from_ff  <= res_mv_ff ? addr_ff : '0;
         rsp_bytes_ff <= res_mv_ff ? cs_ff[FLD_W-1:0] : '0;
      end
   end

   always_comb begin
      off_type t_sz, nxt, nb, ns, m, nn, tot, pre, psz, nsz;
      logic    t_al, has_nxt, has_pre, nfree, pfree;

      state_in     = state_ff;
      after_in     = after_ff;
      type_in      = type_ff;
      a_in         = a_ff;
      hdr_in       = hdr_ff;
      p_in         = p_ff;
      cs_in        = cs_ff;
      pv_in        = pv_ff;
      addr_in      = addr_ff;
      last_in      = last_ff;
      move_in      = move_ff;
      res_ok_in    = res_ok_ff;
      res_mv_in    = res_mv_ff;
      res_addr_in  = res_addr_ff;
      wr_idx_in    = wr_idx_ff;
      q_n_in       = q_n_ff;
      load_q       = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd           = '0;
      wr           = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         pl_addr[i] = '0;
         pl_data[i] = '0;
      end

      t_sz    = size_of(rd_data);
      t_al    = rd_data[0];
      has_nxt = (hdr_ff != last_ff);
      has_pre = (hdr_ff != LEAD_OFF);
      nxt     = hdr_ff + HDR + cs_ff;
      nsz     = t_sz;
      nfree   = has_nxt && !t_al;
      nn      = nxt + HDR + nsz;
      nb      = hdr_ff + HDR + a_ff;
      ns      = cs_ff - a_ff - HDR;
      m       = ns + HDR + nsz;
      tot     = cs_ff + HDR + nsz;
      psz     = size_of(pv_ff);
      pre     = hdr_ff - psz - HDR;
      pfree   = has_pre && !pv_ff[0];

      unique case (state_ff)
         ST_INIT: begin
            wr.en   = 1'b1;
            wr.addr = word_of(LEAD_OFF) + idx_type'(wr_idx_ff);
            wr.data = (wr_idx_ff == '0) ? INIT_TAG : '0;
            if (wr_idx_ff == qidx_type'(1)) begin
               wr_idx_in = '0;
               state_in  = ST_IDLE;
            end else begin
               wr_idx_in = wr_idx_ff + qidx_type'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               type_in     = req_code_type'(req_type);
               addr_in     = req_addr;
               a_in        = (off_type'(req_size) + off_type'(7)) & ~off_type'(7);
               hdr_in      = off_type'(req_addr) - HDR;
               p_in        = LEAD_OFF;
               move_in     = 1'b0;
               res_ok_in   = 1'b0;
               res_mv_in   = 1'b0;
               res_addr_in = '0;
               unique case (req_code_type'(req_type))
                  REQ_ALLOC: begin
                     state_in = (req_size == '0) ? ST_DONE : ST_AL_RD;
                  end
                  REQ_FREE: begin
                     state_in = (req_addr < FLD_W'(HDR_BYTES)) ? ST_DONE : ST_FIND_RD;
                  end
                  REQ_RESIZE: begin
                     priority if (req_addr == '0) begin
                        state_in = (req_size == '0) ? ST_DONE : ST_AL_RD;
                     end else if (req_addr < FLD_W'(HDR_BYTES)) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_FIND_RD;
                     end
                  end
                  REQ_NONE: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FIND_RD: begin
            rd.en    = 1'b1;
            rd.addr  = word_of(p_ff);
            state_in = ST_FIND_CK;
         end
         ST_FIND_CK: begin
            priority if (p_ff == hdr_ff) begin
               if (t_al) begin
                  cs_in    = t_sz;
                  state_in = (type_ff == REQ_FREE || a_ff == '0) ? ST_FR_RD : ST_RZ_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (p_ff == last_ff || p_ff > hdr_ff) begin
               state_in = ST_DONE;
            end else begin
               p_in     = p_ff + HDR + t_sz;
               state_in = ST_FIND_RD;
            end
         end
         ST_RZ_RD: begin
            rd.en    = 1'b1;
            rd.addr  = word_of(nxt);
            state_in = ST_RZ_CK;
         end
         ST_RZ_CK: begin
            after_in = ST_DONE;
            priority if (cs_ff >= a_ff + SPLIT) begin
               // shrink in place, the tail becomes a free block
               res_ok_in   = 1'b1;
               res_addr_in = addr_ff;
               load_q      = 1'b1;
               state_in    = ST_WR;
               pl_addr[0]  = word_of(hdr_ff);
               pl_data[0]  = mk_tag(a_ff, 1'b1);
               pl_addr[1]  = word_of(nb + TAG_STEP);
               pl_data[1]  = mk_tag(a_ff, 1'b1);
               priority if (!has_nxt) begin
                  pl_addr[2] = word_of(nb);
                  pl_data[2] = mk_tag(ns, 1'b0);
                  last_in    = nb;
                  q_n_in     = qcnt_type'(3);
               end else if (t_al) begin
                  pl_addr[2] = word_of(nb);
                  pl_data[2] = mk_tag(ns, 1'b0);
                  pl_addr[3] = word_of(nxt + TAG_STEP);
                  pl_data[3] = mk_tag(ns, 1'b0);
                  q_n_in     = qcnt_type'(4);
               end else if (nxt == last_ff) begin
                  last_in    = nb;
                  pl_addr[2] = word_of(nb);
                  pl_data[2] = mk_tag(m, 1'b0);
                  q_n_in     = qcnt_type'(3);
               end else begin
                  pl_addr[2] = word_of(nn + TAG_STEP);
                  pl_data[2] = mk_tag(m, 1'b0);
                  pl_addr[3] = word_of(nb);
                  pl_data[3] = mk_tag(m, 1'b0);
                  q_n_in     = qcnt_type'(4);
               end
            end else if (cs_ff >= a_ff) begin
               res_ok_in   = 1'b1;
               res_addr_in = addr_ff;
               state_in    = ST_DONE;
            end else if (nfree && tot >= a_ff + SPLIT) begin
               // grow into the next block and split off its rest
               res_ok_in   = 1'b1;
               res_addr_in = addr_ff;
               load_q      = 1'b1;
               state_in    = ST_WR;
               pl_addr[0]  = word_of(hdr_ff);
               pl_data[0]  = mk_tag(a_ff, 1'b1);
               pl_addr[1]  = word_of(nb);
               pl_data[1]  = mk_tag(cs_ff + nsz - a_ff, 1'b0);
               pl_addr[2]  = word_of(nb + TAG_STEP);
               pl_data[2]  = mk_tag(a_ff, 1'b1);
               if (nxt == last_ff) begin
                  last_in = nb;
                  q_n_in  = qcnt_type'(3);
               end else begin
                  pl_addr[3] = word_of(nn + TAG_STEP);
                  pl_data[3] = mk_tag(cs_ff + nsz - a_ff, 1'b0);
                  q_n_in     = qcnt_type'(4);
               end
            end else if (nfree && tot >= a_ff) begin
               res_ok_in   = 1'b1;
               res_addr_in = addr_ff;
               load_q      = 1'b1;
               state_in    = ST_WR;
               pl_addr[0]  = word_of(hdr_ff);
               pl_data[0]  = mk_tag(tot, 1'b1);
               if (nxt == last_ff) begin
                  last_in = hdr_ff;
                  q_n_in  = qcnt_type'(1);
               end else begin
                  pl_addr[1] = word_of(nn + TAG_STEP);
                  pl_data[1] = mk_tag(tot, 1'b1);
                  q_n_in     = qcnt_type'(2);
               end
            end else begin
               // move: allocate elsewhere, then free the old block
               move_in  = 1'b1;
               p_in     = LEAD_OFF;
               state_in = ST_AL_RD;
            end
         end
         ST_AL_RD: begin
            rd.en    = 1'b1;
            rd.addr  = word_of(p_ff);
            state_in = ST_AL_CK;
         end
         ST_AL_CK: begin
            after_in = move_ff ? ST_FR_RD : ST_DONE;
            priority if (!t_al && t_sz >= a_ff + SPLIT) begin
               res_ok_in   = 1'b1;
               res_addr_in = FLD_W'(p_ff + HDR);
               res_mv_in   = move_ff;
               load_q      = 1'b1;
               state_in    = ST_WR;
               pl_addr[0]  = word_of(p_ff);
               pl_data[0]  = mk_tag(a_ff, 1'b1);
               pl_addr[1]  = word_of(p_ff + HDR + a_ff);
               pl_data[1]  = mk_tag(t_sz - a_ff - HDR, 1'b0);
               pl_addr[2]  = word_of(p_ff + HDR + a_ff + TAG_STEP);
               pl_data[2]  = mk_tag(a_ff, 1'b1);
               if (p_ff == last_ff) begin
                  last_in = p_ff + HDR + a_ff;
                  q_n_in  = qcnt_type'(3);
               end else begin
                  pl_addr[3] = word_of(p_ff + HDR + t_sz + TAG_STEP);
                  pl_data[3] = mk_tag(t_sz - a_ff - HDR, 1'b0);
                  q_n_in     = qcnt_type'(4);
               end
            end else if (!t_al && t_sz >= a_ff) begin
               res_ok_in   = 1'b1;
               res_addr_in = FLD_W'(p_ff + HDR);
               res_mv_in   = move_ff;
               load_q      = 1'b1;
               state_in    = ST_WR;
               pl_addr[0]  = word_of(p_ff);
               pl_data[0]  = mk_tag(t_sz, 1'b1);
               if (p_ff == last_ff) begin
                  q_n_in = qcnt_type'(1);
               end else begin
                  pl_addr[1] = word_of(p_ff + HDR + t_sz + TAG_STEP);
                  pl_data[1] = mk_tag(t_sz, 1'b1);
                  q_n_in     = qcnt_type'(2);
               end
            end else if (p_ff == last_ff) begin
               state_in = ST_DONE;
            end else begin
               p_in     = p_ff + HDR + t_sz;
               state_in = ST_AL_RD;
            end
         end
         ST_FR_RD: begin
            rd.en    = 1'b1;
            rd.addr  = word_of(hdr_ff + TAG_STEP);
            state_in = ST_FR_PV;
         end
         ST_FR_PV: begin
            pv_in    = rd_data;
            rd.en    = 1'b1;
            rd.addr  = word_of(nxt);
            state_in = ST_FR_CK;
         end
         ST_FR_CK: begin
            after_in = ST_DONE;
            load_q   = 1'b1;
            state_in = ST_WR;
            priority if (pfree && nfree) begin
               if (nxt == last_ff) begin
                  last_in    = pre;
                  pl_addr[0] = word_of(pre);
                  pl_data[0] = mk_tag(psz + HDR + cs_ff + HDR + nsz, 1'b0);
                  q_n_in     = qcnt_type'(1);
               end else begin
                  pl_addr[0] = word_of(nn + TAG_STEP);
                  pl_data[0] = mk_tag(psz + HDR + cs_ff + HDR + nsz, 1'b0);
                  pl_addr[1] = word_of(pre);
                  pl_data[1] = mk_tag(psz + HDR + cs_ff + HDR + nsz, 1'b0);
                  q_n_in     = qcnt_type'(2);
               end
            end else if (pfree) begin
               pl_addr[0] = word_of(pre);
               pl_data[0] = mk_tag(psz + HDR + cs_ff, 1'b0);
               if (!has_nxt) begin
                  last_in = pre;
                  q_n_in  = qcnt_type'(1);
               end else begin
                  pl_addr[1] = word_of(nxt + TAG_STEP);
                  pl_data[1] = mk_tag(psz + HDR + cs_ff, 1'b0);
                  q_n_in     = qcnt_type'(2);
               end
            end else if (nfree) begin
               if (nxt == last_ff) begin
                  last_in    = hdr_ff;
                  pl_addr[0] = word_of(hdr_ff);
                  pl_data[0] = mk_tag(tot, 1'b0);
                  q_n_in     = qcnt_type'(1);
               end else begin
                  pl_addr[0] = word_of(nn + TAG_STEP);
                  pl_data[0] = mk_tag(tot, 1'b0);
                  pl_addr[1] = word_of(hdr_ff);
                  pl_data[1] = mk_tag(tot, 1'b0);
                  q_n_in     = qcnt_type'(2);
               end
            end else begin
               pl_addr[0] = word_of(hdr_ff);
               pl_data[0] = mk_tag(cs_ff, 1'b0);
               if (has_nxt) begin
                  pl_addr[1] = word_of(nxt + TAG_STEP);
                  pl_data[1] = mk_tag(cs_ff, 1'b0);
                  q_n_in     = qcnt_type'(2);
               end else begin
                  q_n_in = qcnt_type'(1);
               end
            end
         end
         ST_WR: begin
            wr.en   = 1'b1;
            wr.addr = q_addr_ff[wr_idx_ff];
            wr.data = q_data_ff[wr_idx_ff];
            if (qcnt_type'(wr_idx_ff) + qcnt_type'(1) == q_n_ff) begin
               wr_idx_in = '0;
               state_in  = after_ff;
            end else begin
               wr_idx_in = wr_idx_ff + qidx_type'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_move_needed = rsp_mv_ff;
   assign rsp_move_from   = rsp_from_ff;
   assign rsp_move_bytes  = rsp_bytes_ff;

   `BTA_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state_ff != ST_IDLE)
   `BTA_ASSERT_NOW(a_ok_addr, rsp_valid_ff && rsp_ok_ff, rsp_addr_ff != '0)
   `BTA_ASSERT_NOW(a_move_ok, rsp_valid_ff && rsp_mv_ff, rsp_ok_ff)
   `BTA_ASSERT_NOW(a_wr_idx, state_ff == ST_WR, qcnt_type'(wr_idx_ff) < q_n_ff)
   `BTA_ASSERT_NOW(a_last_align, state_ff != ST_INIT, last_ff[2:0] == 3'b000)

endmodule

// File: src/bta_tag_ram.sv
module bta_tag_ram (
   input  logic                clock,
   input  bta_pkg::tag_wr_type wr,
   input  bta_pkg::tag_rd_type rd,
   output bta_pkg::tag_type    rd_data
);
   import bta_pkg::*;

   tag_type mem [WORDS];
   tag_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
